[hw/rtl/button_debounce_short_long_press_assert.svh]
`ifndef BUTTON_DEBOUNCE_SHORT_LONG_PRESS_ASSERT_SVH
`define BUTTON_DEBOUNCE_SHORT_LONG_PRESS_ASSERT_SVH

// same-cycle implication
`define BTNDB_ASSERT_NOW(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("button debounce check failed");

// next-cycle implication
`define BTNDB_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("button debounce check failed");

`endif

[hw/rtl/btndb_pkg.sv]
package btndb_pkg;

	localparam int POLL_MS          = 25;
	localparam int DEBOUNCE_SAMPLES = 2;

	localparam int EQ_W      = 2;
	localparam int HELD_W    = 12;
	localparam int LONG_MS_W = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = LONG_MS_W;
	localparam int POLL_W    = $clog2(POLL_MS + 1);
	localparam int PROD_W    = (HELD_W + POLL_W > LONG_MS_W) ? HELD_W + POLL_W : LONG_MS_W;

	localparam logic [HELD_W-1:0] HELD_MAX  = {HELD_W{1'b1}};
	localparam logic [EQ_W-1:0]   EQ_TARGET = EQ_W'(DEBOUNCE_SAMPLES);

	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_EN = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_MS  = 1'b1;

	typedef struct packed {
		logic                 short_en;
		logic [LONG_MS_W-1:0] long_ms;
	} cfg_t;

	typedef struct packed {
		logic short_press;
		logic long_press;
		logic stable_level;
	} res_t;

endpackage

[hw/rtl/btndb_if.sv]
interface btndb_in_if;
	logic valid;
	logic ready;
	logic level;

	modport source (output valid, output level, input ready);
	modport sink (input valid, input level, output ready);
endinterface

interface btndb_out_if;
	logic valid;
	logic ready;
	logic short_press;
	logic long_press;
	logic stable_level;

	modport source (output valid, output short_press, output long_press, output stable_level,
		input ready);
	modport sink (input valid, input short_press, input long_press, input stable_level,
		output ready);
endinterface

[hw/rtl/btndb_cfg.sv]
module btndb_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [btndb_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [btndb_pkg::CFG_DATA_W-1:0]  cfg_data,
	output btndb_pkg::cfg_t                   cfg
);
	import btndb_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				CFG_SHORT_EN: cfg_q.short_en <= cfg_data[0];
				CFG_LONG_MS:  cfg_q.long_ms  <= cfg_data[LONG_MS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

[hw/rtl/btndb_core.sv]
module btndb_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic            level,
	input  btndb_pkg::cfg_t cfg,
	output btndb_pkg::res_t res
);
	import btndb_pkg::*;

	logic              stable_q, stable_n;
	logic              prev_q, prev_n;
	logic [EQ_W-1:0]   eq_q, eq_n;
	logic [HELD_W-1:0] held_q, held_n;
	logic              long_done_q, long_done_n;
	logic [PROD_W-1:0] held_ms;
	logic              short_p, long_p;

	always_comb begin
		stable_n    = stable_q;
		prev_n      = prev_q;
		eq_n        = eq_q;
		long_done_n = long_done_q;
		short_p     = 1'b0;
		long_p      = 1'b0;

		held_n = held_q;
		if (!stable_q && held_q != HELD_MAX) begin
			held_n = held_q + 1'b1;
		end

		if (level == prev_q) begin
			if (eq_q < EQ_TARGET) begin
				eq_n = eq_q + 1'b1;
			end
			if (eq_n >= EQ_TARGET && level != stable_q) begin
				if (!level) begin
					held_n      = '0;
					long_done_n = 1'b0;
				end else if (!long_done_q && cfg.short_en) begin
					short_p = 1'b1;
				end
				stable_n = level;
			end
		end else begin
			prev_n = level;
			eq_n   = '0;
		end

		held_ms = PROD_W'(held_n) * PROD_W'(POLL_MS);
		if (!stable_n && !long_done_n && cfg.long_ms != '0
				&& held_ms >= PROD_W'(cfg.long_ms)) begin
			long_done_n = 1'b1;
			long_p      = 1'b1;
		end

		res.short_press  = short_p;
		res.long_press   = long_p;
		res.stable_level = stable_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q    <= 1'b1;
			prev_q      <= 1'b1;
			eq_q        <= '0;
			held_q      <= '0;
			long_done_q <= 1'b0;
		end else if (step) begin
			stable_q    <= stable_n;
			prev_q      <= prev_n;
			eq_q        <= eq_n;
			held_q      <= held_n;
			long_done_q <= long_done_n;
		end
	end
endmodule

[hw/rtl/button_debounce_short_long_press.sv]
// Debounced active-low button with short- and long-press pulses. Each input
// transfer is one poll tick carrying the sampled pin level and yields exactly
// one result: short_press, long_press and the debounced stable_level. A tick is
// taken every clock cycle unless the input is stalled; the input register
// captures the tick, the combinational state update runs once the result
// register is free, and the result register holds its outcome. Backpressure
// on the result side stalls the input only once both registers are full.
// Configuration writes take effect on the next tick.
module button_debounce_short_long_press (
	input  logic                              clk,
	input  logic                              arst_n,
	btndb_in_if.sink                          button,
	btndb_out_if.source                       result,
	input  logic                              cfg_wen,
	input  logic [btndb_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [btndb_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import btndb_pkg::*;

	cfg_t cfg;
	res_t res_core;
	res_t res_s2;
	logic valid_s1;
	logic level_s1;
	logic res_valid_s2;
	logic step;

	assign step         = valid_s1 && (!res_valid_s2 || result.ready);
	assign button.ready = !valid_s1 || step;

	btndb_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	btndb_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.level  (level_s1),
		.cfg    (cfg),
		.res    (res_core)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			res_valid_s2 <= 1'b0;
		end else begin
			if (button.ready) begin
				valid_s1 <= button.valid;
			end
			if (step) begin
				res_valid_s2 <= 1'b1;
			end else if (result.ready) begin
				res_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (button.valid && button.ready) begin
			level_s1 <= button.level;
		end
		if (step) begin
			res_s2 <= res_core;
		end
	end

	assign result.valid        = res_valid_s2;
	assign result.short_press  = res_s2.short_press;
	assign result.long_press   = res_s2.long_press;
	assign result.stable_level = res_s2.stable_level;
endmodule

[hw/rtl/btndb_checker.sv]
`include "button_debounce_short_long_press_assert.svh"

module btndb_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic short_press,
	input logic long_press,
	input logic stable_level
);
	`BTNDB_ASSERT_NOW(a_one_pulse, clk, arst_n, out_valid, !(short_press && long_press))
	`BTNDB_ASSERT_NOW(a_short_on_release, clk, arst_n, out_valid && short_press, stable_level)
	`BTNDB_ASSERT_NOW(a_long_while_held, clk, arst_n, out_valid && long_press, !stable_level)
	`BTNDB_ASSERT_NEXT(a_result_holds, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(short_press) && $stable(long_press) && $stable(stable_level))
endmodule

bind button_debounce_short_long_press btndb_checker u_btndb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.short_press  (result.short_press),
	.long_press   (result.long_press),
	.stable_level (result.stable_level)
);
